// File: rtl/core/stap_pkg.sv
// Shared types and constants for the STUN/TURN attribute parser.
// Used by the parser, the word queue, the emitter and the top level.
`default_nettype none

package stap_pkg;

	localparam int MAX_TEXT_BYTES = 128;
	localparam int QDEPTH         = 4;
	localparam int QAW            = $clog2(QDEPTH);
	localparam int QCW            = $clog2(QDEPTH + 1);

	localparam logic [31:0] COOKIE = 32'h2112A442;

	localparam logic [16:0] HDR_LEN     = 17'd20;
	localparam logic [16:0] POS_LEN_HI  = 17'd2;
	localparam logic [16:0] POS_LEN_LO  = 17'd3;
	localparam logic [16:0] POS_HDR_END = 17'd19;
	localparam logic [16:0] POS_MAX     = 17'h1FFFF;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_ATTR   = 3'd1;
	localparam logic [2:0] PH_VALUE  = 3'd2;
	localparam logic [2:0] PH_PAD    = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SHORT    = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;
	localparam logic [1:0] ST_TRUNC    = 2'd3;

	localparam logic [1:0] KIND_REALM   = 2'd0;
	localparam logic [1:0] KIND_NONCE   = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	localparam logic [15:0] AT_ERROR_CODE = 16'h0009;
	localparam logic [15:0] AT_LIFETIME   = 16'h000D;
	localparam logic [15:0] AT_REALM      = 16'h0014;
	localparam logic [15:0] AT_NONCE      = 16'h0015;
	localparam logic [15:0] AT_XOR_RELAY  = 16'h0016;

	localparam logic [14:0] MAX_ERROR_CODE = 15'd25755;

	typedef struct packed {
		logic        text_valid;
		logic [1:0]  text_kind;
		logic [7:0]  text_byte;
		logic        sum_valid;
		logic [1:0]  status;
		logic [14:0] code;
		logic [15:0] port;
		logic [31:0] addr;
		logic [31:0] life;
		logic [15:0] nlen;
	} stap_word_t;

	typedef struct packed {
		logic head_valid;
		logic full;
	} stap_qstat_t;

endpackage

`default_nettype wire

// File: rtl/core/stun_attribute_parser.sv
// Top level of the STUN/TURN attribute parser.
// Instantiates stap_parse, stap_queue and stap_emit; uses stap_pkg.
//
// Takes one message byte per cycle while in_stall is low and gives at most
// one result word per cycle. The parser handles each byte in the cycle it is
// accepted; words that carry a REALM/NONCE byte or the packet summary enter a
// four-word queue, and the emitter loads them into its output register. A
// last byte that also carries text yields two results, the text byte first and
// then the summary. in_stall rises only while the queue is full, i.e. after
// out_stall has held results back. nonce_known is written through cfg_we.
`default_nettype none

module stun_attribute_parser import stap_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic [16:0] packet_size,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       result_kind,
	output logic [7:0]       text_byte,
	output logic [1:0]       parse_status,
	output logic [14:0]      stun_error_code,
	output logic [15:0]      relayed_port,
	output logic [31:0]      relayed_address,
	output logic [31:0]      lifetime_seconds,
	output logic [15:0]      nonce_length,
	output logic             last_result
);

	logic        accept;
	logic        push;
	logic        pop;
	stap_word_t  push_word;
	stap_word_t  head_word;
	stap_qstat_t qstat;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;

	stap_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.accept      (accept),
		.data_byte   (data_byte),
		.packet_size (packet_size),
		.last_byte   (last_byte),
		.push        (push),
		.push_word   (push_word)
	);

	stap_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head_word (head_word),
		.qstat     (qstat)
	);

	stap_emit u_emit (
		.clk              (clk),
		.arst_n           (arst_n),
		.head_word        (head_word),
		.qstat            (qstat),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_kind      (result_kind),
		.text_byte        (text_byte),
		.parse_status     (parse_status),
		.stun_error_code  (stun_error_code),
		.relayed_port     (relayed_port),
		.relayed_address  (relayed_address),
		.lifetime_seconds (lifetime_seconds),
		.nonce_length     (nonce_length),
		.last_result      (last_result)
	);

endmodule

`default_nettype wire

// File: rtl/core/stap_parse.sv
// Front part: walks header and attributes one byte per accepted word.
// Produces one queue word per byte that yields text or a summary. Uses stap_pkg.
`default_nettype none

module stap_parse import stap_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        accept,
	input  wire logic [7:0]  data_byte,
	input  wire logic [16:0] packet_size,
	input  wire logic        last_byte,
	output logic             push,
	output stap_word_t       push_word
);

	logic        nonce_known_q;
	logic [16:0] pos_q, pos_n;
	logic [15:0] mlen_q, mlen_n;
	logic [2:0]  phase_q, phase_n;
	logic [15:0] atype_q, atype_n;
	logic [15:0] alen_q, alen_n;
	logic [16:0] aoff_q, aoff_n;
	logic [63:0] vwin_q, vwin_n;
	logic [31:0] life_q, life_n;
	logic [31:0] addr_q, addr_n;
	logic [14:0] code_q, code_n;
	logic [15:0] port_q, port_n;
	logic [15:0] nlen_q, nlen_n;
	logic        realm_held_q, realm_held_n;
	logic [1:0]  err_q, err_n;
	logic        apply_en;
	logic        realm_txt, nonce_txt, text_en;
	logic [1:0]  pad;
	logic [2:0]  lane;

	always_comb begin
		pos_n        = pos_q;
		mlen_n       = mlen_q;
		phase_n      = phase_q;
		atype_n      = atype_q;
		alen_n       = alen_q;
		aoff_n       = aoff_q;
		vwin_n       = vwin_q;
		life_n       = life_q;
		addr_n       = addr_q;
		code_n       = code_q;
		port_n       = port_q;
		nlen_n       = nlen_q;
		realm_held_n = realm_held_q;
		err_n        = err_q;
		apply_en     = 1'b0;
		text_en      = 1'b0;
		pad          = 2'd0;
		lane         = 3'd7 - aoff_q[2:0];
		realm_txt    = (atype_q == AT_REALM) && !realm_held_q;
		nonce_txt    = (atype_q == AT_NONCE) && !nonce_known_q;

		if (err_n == ST_OK && packet_size < HDR_LEN)
			err_n = ST_SHORT;

		if (err_n == ST_OK && pos_q < packet_size) begin
			case (phase_q)
				PH_HEADER: begin
					if (pos_q == POS_LEN_HI)
						mlen_n = {data_byte, 8'd0};
					if (pos_q == POS_LEN_LO) begin
						mlen_n = mlen_q | {8'd0, data_byte};
						if (packet_size != HDR_LEN + {1'b0, mlen_n})
							err_n = ST_MISMATCH;
					end
					if (pos_q == POS_HDR_END) begin
						phase_n = PH_ATTR;
						aoff_n  = 17'd0;
					end
				end
				PH_ATTR: begin
					case (aoff_q[1:0])
						2'd0: begin
							if ((packet_size - pos_q) < 17'd4) begin
								phase_n = PH_DONE;
							end else begin
								atype_n = {data_byte, 8'd0};
								aoff_n  = aoff_q + 17'd1;
							end
						end
						2'd1: begin
							atype_n = atype_q | {8'd0, data_byte};
							aoff_n  = aoff_q + 17'd1;
						end
						2'd2: begin
							alen_n = {data_byte, 8'd0};
							aoff_n = aoff_q + 17'd1;
						end
						default: begin
							alen_n = alen_q | {8'd0, data_byte};
							vwin_n = 64'd0;
							if ((packet_size - pos_q - 17'd1) < {1'b0, alen_n}) begin
								err_n   = ST_TRUNC;
								phase_n = PH_DONE;
							end else if (alen_n == 16'd0) begin
								apply_en = 1'b1;
							end else begin
								phase_n = PH_VALUE;
								aoff_n  = 17'd0;
							end
						end
					endcase
				end
				PH_VALUE: begin
					if (aoff_q < 17'd8)
						vwin_n[{lane, 3'b000} +: 8] = data_byte;
					text_en = (realm_txt || nonce_txt) && (aoff_q < 17'(MAX_TEXT_BYTES));
					aoff_n  = aoff_q + 17'd1;
					if (aoff_n >= {1'b0, alen_q})
						apply_en = 1'b1;
				end
				PH_PAD: begin
					if (aoff_q != 17'd0)
						aoff_n = aoff_q - 17'd1;
					if (aoff_n == 17'd0)
						phase_n = PH_ATTR;
				end
				default: begin
				end
			endcase
		end

		if (apply_en) begin
			case (atype_n)
				AT_ERROR_CODE: code_n = 15'({7'd0, vwin_n[47:40]} * 15'd100)
						+ {7'd0, vwin_n[39:32]};
				AT_XOR_RELAY: begin
					port_n = vwin_n[47:32] ^ COOKIE[31:16];
					addr_n = vwin_n[31:0] ^ COOKIE;
				end
				AT_LIFETIME: life_n = vwin_n[63:32];
				AT_REALM: begin
					if (!realm_held_q)
						realm_held_n = (vwin_n[63:56] != 8'd0);
				end
				AT_NONCE: begin
					if (!nonce_known_q)
						nlen_n = alen_n;
				end
				default: begin
				end
			endcase
			pad     = 2'd0 - alen_n[1:0];
			aoff_n  = {15'd0, pad};
			phase_n = (pad != 2'd0) ? PH_PAD : PH_ATTR;
		end

		if (pos_q != POS_MAX)
			pos_n = pos_q + 17'd1;

		if (last_byte && err_n == ST_OK && pos_q < POS_HDR_END)
			err_n = ST_SHORT;
	end

	always_comb begin
		push_word.text_valid = text_en;
		push_word.text_kind  = realm_txt ? KIND_REALM : KIND_NONCE;
		push_word.text_byte  = data_byte;
		push_word.sum_valid  = last_byte;
		push_word.status     = err_n;
		push_word.code       = code_n;
		push_word.port       = port_n;
		push_word.addr       = addr_n;
		push_word.life       = life_n;
		push_word.nlen       = nlen_n;
		push                 = accept && (text_en || last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonce_known_q <= 1'b0;
		end else if (cfg_we) begin
			nonce_known_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= 17'd0;
			mlen_q       <= 16'd0;
			phase_q      <= PH_HEADER;
			atype_q      <= 16'd0;
			alen_q       <= 16'd0;
			aoff_q       <= 17'd0;
			vwin_q       <= 64'd0;
			life_q       <= 32'd0;
			addr_q       <= 32'd0;
			code_q       <= 15'd0;
			port_q       <= 16'd0;
			nlen_q       <= 16'd0;
			realm_held_q <= 1'b0;
			err_q        <= ST_OK;
		end else if (accept) begin
			realm_held_q <= realm_held_n;
			if (last_byte) begin
				pos_q   <= 17'd0;
				mlen_q  <= 16'd0;
				phase_q <= PH_HEADER;
				atype_q <= 16'd0;
				alen_q  <= 16'd0;
				aoff_q  <= 17'd0;
				vwin_q  <= 64'd0;
				life_q  <= 32'd0;
				addr_q  <= 32'd0;
				code_q  <= 15'd0;
				port_q  <= 16'd0;
				nlen_q  <= 16'd0;
				err_q   <= ST_OK;
			end else begin
				pos_q   <= pos_n;
				mlen_q  <= mlen_n;
				phase_q <= phase_n;
				atype_q <= atype_n;
				alen_q  <= alen_n;
				aoff_q  <= aoff_n;
				vwin_q  <= vwin_n;
				life_q  <= life_n;
				addr_q  <= addr_n;
				code_q  <= code_n;
				port_q  <= port_n;
				nlen_q  <= nlen_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/stap_queue.sv
// Short word queue between parser and emitter.
// Register storage, one write and one read place per cycle. Uses stap_pkg.
`default_nettype none

module stap_queue import stap_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire stap_word_t push_word,
	input  wire logic       pop,
	output stap_word_t      head_word,
	output stap_qstat_t     qstat
);

	stap_word_t           mem_q [QDEPTH];
	logic [QAW-1:0]       wr_q, rd_q;
	logic [QCW-1:0]       count_q;

	assign head_word       = mem_q[rd_q];
	assign qstat.head_valid = (count_q != '0);
	assign qstat.full       = (count_q == QCW'(QDEPTH));

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/stap_emit.sv
// Back part: turns queue words into result words in an output register.
// A word with text and summary leaves as two results. Uses stap_pkg.
`default_nettype none

module stap_emit import stap_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire stap_word_t   head_word,
	input  wire stap_qstat_t  qstat,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [1:0]        result_kind,
	output logic [7:0]        text_byte,
	output logic [1:0]        parse_status,
	output logic [14:0]       stun_error_code,
	output logic [15:0]       relayed_port,
	output logic [31:0]       relayed_address,
	output logic [31:0]       lifetime_seconds,
	output logic [15:0]       nonce_length,
	output logic              last_result
);

	logic out_valid_q;
	logic text_sent_q;
	logic free, sel_text, load;

	assign free     = !out_valid_q || !out_stall;
	assign load     = free && qstat.head_valid;
	assign sel_text = head_word.text_valid && !text_sent_q;
	assign pop      = load && !(sel_text && head_word.sum_valid);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			text_sent_q <= 1'b0;
		end else if (free) begin
			out_valid_q <= qstat.head_valid;
			if (load)
				text_sent_q <= sel_text && head_word.sum_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (sel_text) begin
				result_kind      <= head_word.text_kind;
				text_byte        <= head_word.text_byte;
				parse_status     <= ST_OK;
				stun_error_code  <= 15'd0;
				relayed_port     <= 16'd0;
				relayed_address  <= 32'd0;
				lifetime_seconds <= 32'd0;
				nonce_length     <= 16'd0;
				last_result      <= 1'b0;
			end else begin
				result_kind      <= KIND_SUMMARY;
				text_byte        <= 8'd0;
				parse_status     <= head_word.status;
				stun_error_code  <= head_word.code;
				relayed_port     <= head_word.port;
				relayed_address  <= head_word.addr;
				lifetime_seconds <= head_word.life;
				nonce_length     <= head_word.nlen;
				last_result      <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/stap_checker.sv
// Port-level checks for stun_attribute_parser, bound to the top level.
// Uses stap_pkg for result kinds and limits.
`default_nettype none

module stap_checker import stap_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  result_kind,
	input wire logic [7:0]  text_byte,
	input wire logic [1:0]  parse_status,
	input wire logic [14:0] stun_error_code,
	input wire logic [15:0] nonce_length,
	input wire logic        last_result
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_last_is_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_result == (result_kind == KIND_SUMMARY)))
		else $error("last_result disagrees with result_kind");

	a_text_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_SUMMARY |->
			parse_status == ST_OK && stun_error_code == 15'd0 && nonce_length == 16'd0)
		else $error("text word carries summary fields");

	a_summary_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_SUMMARY |->
			text_byte == 8'd0 && stun_error_code <= MAX_ERROR_CODE)
		else $error("summary word out of range");

endmodule

bind stun_attribute_parser stap_checker u_chk (.*);

`default_nettype wire

// File: verif/tb_stun_attribute_parser.sv
// Self-checking testbench for the STUN/TURN attribute parser.
// Runs directed packets, then random packets, against a built-in parse predictor.
// Depends on stap_pkg and stun_attribute_parser from the rtl/core folder.

module tb_stun_attribute_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import stap_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 200;
	localparam int RANDOM_WORDS = 700;
	localparam int N_PHASES     = 6;
	localparam int N_DIRECTED   = 19;

	typedef struct packed {
		logic [7:0]  octet;
		logic [16:0] pkt_size;
		logic        is_last;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  text;
		logic [1:0]  status;
		logic [14:0] code;
		logic [15:0] port;
		logic [31:0] addr;
		logic [31:0] life;
		logic [15:0] nlen;
		logic        summary;
	} parse_result_t;

	typedef struct packed {
		logic [16:0] n_sent;
		logic [16:0] pkt_size;
		logic [15:0] len_field;
		logic [15:0] attr_kind;
		logic [15:0] attr_len;
		logic [63:0] fill;
		logic        typed;
		logic [1:0]  status;
		logic [14:0] code;
		logic [15:0] port;
		logic [31:0] addr;
		logic [31:0] life;
		logic [15:0] nlen;
	} dir_row_t;

	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;
	typedef enum logic [2:0] {
		PK_CLEAN, PK_MISMATCH, PK_TRUNC, PK_EARLY, PK_PAST, PK_NOISE, PK_SHORT
	} pkt_flavour_e;

	localparam dir_row_t HOLD_ROW = '{17'd124, 17'd124, 16'd104, AT_NONCE, 16'd100,
		64'h4E4F_4E43_455F_3031, 1'b0, ST_OK, 15'd0, 16'd0, 32'd0, 32'd0, 16'd0};

	dir_row_t directed_rows [N_DIRECTED] = '{
		'{17'd1, 17'd0, 16'd0, 16'd0, 16'd0, 64'd0, 1'b1,
			ST_SHORT, 15'd0, 16'd0, 32'd0, 32'd0, 16'd0},
		'{17'd19, 17'd19, 16'd0, 16'd0, 16'd0, 64'd0, 1'b1,
			ST_SHORT, 15'd0, 16'd0, 32'd0, 32'd0, 16'd0},
		'{17'd20, 17'd20, 16'd0, 16'd0, 16'd0, 64'd0, 1'b1,
			ST_OK, 15'd0, 16'd0, 32'd0, 32'd0, 16'd0},
		'{17'd24, 17'd24, 16'd0, 16'd0, 16'd0, 64'd0, 1'b1,
			ST_MISMATCH, 15'd0, 16'd0, 32'd0, 32'd0, 16'd0},
		'{17'd20, 17'd65555, 16'hFFFF, 16'd0, 16'd0, 64'd0, 1'b1,
			ST_OK, 15'd0, 16'd0, 32'd0, 32'd0, 16'd0},
		'{17'd28, 17'd28, 16'd8, AT_ERROR_CODE, 16'd4, 64'h0000_FFFF_0000_0000, 1'b1,
			ST_OK, MAX_ERROR_CODE, 16'd0, 32'd0, 32'd0, 16'd0},
		'{17'd28, 17'd28, 16'd8, AT_LIFETIME, 16'd4, 64'hFFFF_FFFF_0000_0000, 1'b1,
			ST_OK, 15'd0, 16'd0, 32'd0, 32'hFFFF_FFFF, 16'd0},
		'{17'd32, 17'd32, 16'd12, AT_XOR_RELAY, 16'd8, 64'h0001_FFFF_FFFF_FFFF, 1'b1,
			ST_OK, 15'd0, 16'hDEED, 32'hDEED_5BBD, 32'd0, 16'd0},
		'{17'd28, 17'd28, 16'd8, AT_ERROR_CODE, 16'd5, 64'h0000_0102_0300_0000, 1'b1,
			ST_TRUNC, 15'd0, 16'd0, 32'd0, 32'd0, 16'd0},
		'{17'd28, 17'd28, 16'd8, AT_ERROR_CODE, 16'd2, 64'h0405_0607_0000_0000, 1'b0,
			ST_OK, 15'd0, 16'd0, 32'd0, 32'd0, 16'd0},
		'{17'd27, 17'd27, 16'd7, AT_ERROR_CODE, 16'd3, 64'h0000_0400_0000_0000, 1'b0,
			ST_OK, 15'd0, 16'd0, 32'd0, 32'd0, 16'd0},
		'{17'd24, 17'd24, 16'd4, AT_LIFETIME, 16'd0, 64'd0, 1'b0,
			ST_OK, 15'd0, 16'd0, 32'd0, 32'd0, 16'd0},
		'{17'd32, 17'd32, 16'd12, AT_REALM, 16'd5, 64'h0061_6263_6465_6667, 1'b0,
			ST_OK, 15'd0, 16'd0, 32'd0, 32'd0, 16'd0},
		'{17'd32, 17'd32, 16'd12, AT_NONCE, 16'd6, 64'h6E6F_6E63_6531_3233, 1'b0,
			ST_OK, 15'd0, 16'd0, 32'd0, 32'd0, 16'd0},
		'{17'd28, 17'd28, 16'd8, 16'h8022, 16'd4, 64'hDEAD_BEEF_0000_0000, 1'b1,
			ST_OK, 15'd0, 16'd0, 32'd0, 32'd0, 16'd0},
		'{17'd23, 17'd23, 16'd3, 16'd0, 16'd0, 64'd0, 1'b1,
			ST_OK, 15'd0, 16'd0, 32'd0, 32'd0, 16'd0},
		'{17'd26, 17'd32, 16'd12, AT_LIFETIME, 16'd8, 64'h0102_0304_0506_0708, 1'b1,
			ST_OK, 15'd0, 16'd0, 32'd0, 32'd0, 16'd0},
		'{17'd24, 17'd20, 16'd0, 16'd0, 16'd0, 64'd0, 1'b1,
			ST_OK, 15'd0, 16'd0, 32'd0, 32'd0, 16'd0},
		'{17'd164, 17'd164, 16'd144, AT_NONCE, 16'd140, 64'h3031_3233_3435_3637, 1'b0,
			ST_OK, 15'd0, 16'd0, 32'd0, 32'd0, 16'd0}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic [16:0] packet_size;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  result_kind;
	logic [7:0]  text_byte;
	logic [1:0]  parse_status;
	logic [14:0] stun_error_code;
	logic [15:0] relayed_port;
	logic [31:0] relayed_address;
	logic [31:0] lifetime_seconds;
	logic [15:0] nonce_length;
	logic        last_result;

	stun_attribute_parser u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.data_byte        (data_byte),
		.packet_size      (packet_size),
		.last_byte        (last_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_kind      (result_kind),
		.text_byte        (text_byte),
		.parse_status     (parse_status),
		.stun_error_code  (stun_error_code),
		.relayed_port     (relayed_port),
		.relayed_address  (relayed_address),
		.lifetime_seconds (lifetime_seconds),
		.nonce_length     (nonce_length),
		.last_result      (last_result)
	);

	// parse predictor state
	logic [16:0] byte_pos     = '0;
	logic [15:0] msg_len      = '0;
	logic [2:0]  parse_ph     = PH_HEADER;
	logic [15:0] attr_type    = '0;
	logic [15:0] attr_len     = '0;
	logic [16:0] attr_off     = '0;
	logic [63:0] value_win    = '0;
	logic [14:0] got_code     = '0;
	logic [15:0] got_port     = '0;
	logic [31:0] got_addr     = '0;
	logic [31:0] got_life     = '0;
	logic [15:0] got_nlen     = '0;
	logic        realm_locked = 1'b0;
	logic [1:0]  pkt_status   = ST_OK;
	logic        nonce_cfg    = 1'b0;

	parse_result_t parser_words_due [$];
	parse_result_t fixed_summary;
	bit            fixed_summary_on = 1'b0;
	in_word_t      tx_words [$];
	int            burst_left = 0;
	int            fail_count = 0;
	int            quiet_cycles = 0;
	bit            hold_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void close_attribute();
		logic [1:0] pad;
		case (attr_type)
			AT_ERROR_CODE: got_code = 15'(int'(value_win[47:40]) * 100 + int'(value_win[39:32]));
			AT_XOR_RELAY: begin
				got_port = value_win[47:32] ^ COOKIE[31:16];
				got_addr = value_win[31:0] ^ COOKIE;
			end
			AT_LIFETIME: got_life = value_win[63:32];
			AT_REALM: if (!realm_locked) realm_locked = (value_win[63:56] != 8'h00);
			AT_NONCE: if (!nonce_cfg) got_nlen = attr_len;
			default: ;
		endcase
		pad = 2'd0 - attr_len[1:0];
		attr_off = '0;
		if (pad != 2'd0) begin
			attr_off = 17'(pad);
			parse_ph = PH_PAD;
		end else begin
			parse_ph = PH_ATTR;
		end
	endfunction

	task automatic parse_byte(input in_word_t w);
		logic [16:0]   p;
		bit            realm_txt;
		bit            nonce_txt;
		parse_result_t r;
		p = byte_pos;
		if (pkt_status == ST_OK && w.pkt_size < HDR_LEN)
			pkt_status = ST_SHORT;
		if (pkt_status == ST_OK && p < w.pkt_size) begin
			case (parse_ph)
				PH_HEADER: begin
					if (p == POS_LEN_HI)
						msg_len = {w.octet, 8'h00};
					if (p == POS_LEN_LO) begin
						msg_len[7:0] = w.octet;
						if (w.pkt_size != HDR_LEN + msg_len)
							pkt_status = ST_MISMATCH;
					end
					if (p == POS_HDR_END) begin
						parse_ph = PH_ATTR;
						attr_off = '0;
					end
				end
				PH_ATTR: begin
					if (attr_off == 0) begin
						if (w.pkt_size - p < 4) begin
							parse_ph = PH_DONE;
						end else begin
							attr_type = {w.octet, 8'h00};
							attr_off++;
						end
					end else if (attr_off == 1) begin
						attr_type[7:0] = w.octet;
						attr_off++;
					end else if (attr_off == 2) begin
						attr_len = {w.octet, 8'h00};
						attr_off++;
					end else begin
						attr_len[7:0] = w.octet;
						value_win = '0;
						if (w.pkt_size - (p + 1) < attr_len) begin
							pkt_status = ST_TRUNC;
							parse_ph = PH_DONE;
						end else if (attr_len == 0) begin
							close_attribute();
						end else begin
							parse_ph = PH_VALUE;
							attr_off = '0;
						end
					end
				end
				PH_VALUE: begin
					realm_txt = (attr_type == AT_REALM) && !realm_locked;
					nonce_txt = (attr_type == AT_NONCE) && !nonce_cfg;
					if (attr_off < 8)
						value_win[63 - 8 * attr_off -: 8] = w.octet;
					if ((realm_txt || nonce_txt) && attr_off < MAX_TEXT_BYTES) begin
						r = '0;
						r.kind = realm_txt ? KIND_REALM : KIND_NONCE;
						r.text = w.octet;
						parser_words_due.push_back(r);
					end
					attr_off++;
					if (attr_off >= attr_len)
						close_attribute();
				end
				PH_PAD: begin
					if (attr_off > 0)
						attr_off--;
					if (attr_off == 0)
						parse_ph = PH_ATTR;
				end
				default: ;
			endcase
		end
		if (byte_pos != POS_MAX)
			byte_pos++;
		if (w.is_last) begin
			if (pkt_status == ST_OK && p < POS_HDR_END)
				pkt_status = ST_SHORT;
			r = '0;
			r.kind = KIND_SUMMARY;
			r.status = pkt_status;
			r.code = got_code;
			r.port = got_port;
			r.addr = got_addr;
			r.life = got_life;
			r.nlen = got_nlen;
			r.summary = 1'b1;
			parser_words_due.push_back(fixed_summary_on ? fixed_summary : r);
			byte_pos = '0;
			msg_len = '0;
			parse_ph = PH_HEADER;
			attr_type = '0;
			attr_len = '0;
			attr_off = '0;
			value_win = '0;
			got_code = '0;
			got_port = '0;
			got_addr = '0;
			got_life = '0;
			got_nlen = '0;
			pkt_status = ST_OK;
		end
	endtask

	// offer one word, hold it until taken, then maybe pause
	task automatic send_word(input in_word_t w);
		in_valid <= 1'b1;
		data_byte <= w.octet;
		packet_size <= w.pkt_size;
		last_byte <= w.is_last;
		do @(posedge clk); while (in_stall !== 1'b0);
		parse_byte(w);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 300)
				: $urandom_range(0, 24);
		end
	endtask

	task automatic send_packet();
		foreach (tx_words[i])
			send_word(tx_words[i]);
		tx_words.delete();
	endtask

	task automatic set_nonce_known(input bit v);
		in_valid <= 1'b0;
		while (parser_words_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		nonce_cfg = v;
	endtask

	task automatic build_row(input dir_row_t r);
		in_word_t w;
		logic [7:0] b;
		int j;
		for (int i = 0; i < r.n_sent; i++) begin
			j = i - 20;
			if (i == 0)
				b = 8'h01;
			else if (i == 1)
				b = 8'h13;
			else if (i == 2)
				b = r.len_field[15:8];
			else if (i == 3)
				b = r.len_field[7:0];
			else if (i < 8)
				b = 8'(COOKIE >> (24 - 8 * (i - 4)));
			else if (i < 20)
				b = 8'h40 + 8'(i);
			else if (j == 0)
				b = r.attr_kind[15:8];
			else if (j == 1)
				b = r.attr_kind[7:0];
			else if (j == 2)
				b = r.attr_len[15:8];
			else if (j == 3)
				b = r.attr_len[7:0];
			else if (j - 4 < r.attr_len)
				b = 8'(r.fill >> (56 - 8 * ((j - 4) % 8)));
			else
				b = 8'h00;
			w.octet = b;
			w.pkt_size = r.pkt_size;
			w.is_last = (i == r.n_sent - 1);
			tx_words.push_back(w);
		end
	endtask

	task automatic make_random_packet(output int unsigned useful);
		logic [7:0]   body [$];
		logic [7:0]   hdr [20];
		logic [15:0]  t;
		logic [15:0]  len_field;
		logic [16:0]  sz;
		int unsigned  n_attr;
		int unsigned  alen;
		int unsigned  pad;
		int unsigned  mlen;
		int unsigned  total;
		pkt_flavour_e fl;
		in_word_t     w;
		case ($urandom_range(0, 19))
			12: fl = PK_MISMATCH;
			13: fl = PK_TRUNC;
			14: fl = PK_EARLY;
			15: fl = PK_PAST;
			16, 17: fl = PK_NOISE;
			18: fl = PK_SHORT;
			default: fl = PK_CLEAN;
		endcase
		if (fl == PK_NOISE || fl == PK_SHORT) begin
			total = (fl == PK_NOISE) ? $urandom_range(1, 40) : $urandom_range(1, 24);
			sz = 17'($urandom_range(0, 19));
			for (int i = 0; i < total; i++) begin
				w.octet = 8'($urandom);
				if (fl == PK_NOISE)
					w.pkt_size = ($urandom_range(0, 3) == 0) ? 17'($urandom)
						: 17'($urandom_range(0, 60));
				else
					w.pkt_size = sz;
				w.is_last = (i == total - 1);
				tx_words.push_back(w);
			end
			useful = total;
			return;
		end
		pad = 0;
		n_attr = $urandom_range(0, 4);
		repeat (n_attr) begin
			case ($urandom_range(0, 6))
				0: begin t = AT_ERROR_CODE; alen = 4; end
				1: begin t = AT_LIFETIME; alen = 4; end
				2: begin t = AT_REALM; alen = $urandom_range(0, 20); end
				3: begin t = AT_NONCE; alen = $urandom_range(0, 20); end
				4: begin t = AT_XOR_RELAY; alen = 8; end
				default: begin t = 16'($urandom); alen = $urandom_range(0, 12); end
			endcase
			if ($urandom_range(0, 4) == 0)
				alen = $urandom_range(0, 12);
			if ((t == AT_REALM || t == AT_NONCE) && $urandom_range(0, 15) == 0)
				alen = $urandom_range(100, 140);
			body.push_back(t[15:8]);
			body.push_back(t[7:0]);
			body.push_back(8'(alen >> 8));
			body.push_back(8'(alen));
			for (int k = 0; k < alen; k++)
				body.push_back((t == AT_REALM && k == 0 && $urandom_range(0, 39) != 0)
					? 8'h00 : 8'($urandom));
			pad = (4 - alen % 4) % 4;
			repeat (pad) body.push_back(8'($urandom));
		end
		if (pad != 0 && $urandom_range(0, 3) == 0)
			repeat (pad) void'(body.pop_back());
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
		if (fl == PK_TRUNC) begin
			t = $urandom_range(0, 1) ? AT_NONCE : 16'($urandom);
			alen = $urandom_range(1, 300);
			body.push_back(t[15:8]);
			body.push_back(t[7:0]);
			body.push_back(8'(alen >> 8));
			body.push_back(8'(alen));
			repeat ($urandom_range(0, (alen > 8) ? 8 : alen - 1))
				body.push_back(8'($urandom));
		end
		mlen = body.size();
		sz = 17'(20 + mlen);
		len_field = 16'(mlen);
		if (fl == PK_MISMATCH)
			len_field = len_field ^ (16'd1 << $urandom_range(0, 15));
		for (int i = 0; i < 20; i++)
			hdr[i] = 8'($urandom);
		hdr[2] = len_field[15:8];
		hdr[3] = len_field[7:0];
		for (int i = 0; i < 4; i++)
			hdr[4 + i] = 8'(COOKIE >> (24 - 8 * i));
		total = 20 + mlen;
		if (fl == PK_EARLY)
			total = $urandom_range(1, total - 1);
		if (fl == PK_PAST)
			total = total + $urandom_range(1, 6);
		for (int i = 0; i < total; i++) begin
			if (i < 20)
				w.octet = hdr[i];
			else if (i - 20 < mlen)
				w.octet = body[i - 20];
			else
				w.octet = 8'($urandom);
			w.pkt_size = sz;
			w.is_last = (i == total - 1);
			tx_words.push_back(w);
		end
		useful = (total < sz) ? total : sz;
	endtask

	function automatic void check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		parse_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (parser_words_due.size() == 0) begin
				$display("%0t: result word with nothing expected, kind %0d", $time,
					result_kind);
				fail_count++;
			end else begin
				e = parser_words_due.pop_front();
				check_field("result_kind", 32'(e.kind), 32'(result_kind));
				check_field("text_byte", 32'(e.text), 32'(text_byte));
				check_field("parse_status", 32'(e.status), 32'(parse_status));
				check_field("stun_error_code", 32'(e.code), 32'(stun_error_code));
				check_field("relayed_port", 32'(e.port), 32'(relayed_port));
				check_field("relayed_address", e.addr, relayed_address);
				check_field("lifetime_seconds", e.life, lifetime_seconds);
				check_field("nonce_length", 32'(e.nlen), 32'(nonce_length));
				check_field("last_result", 32'(e.summary), 32'(last_result));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("stun_attribute_parser regression: fail");
			$finish;
		end
	end

	initial begin
		rx_mode_e mode;
		int       mode_left;
		int       tick;
		mode = RX_FREE;
		mode_left = 0;
		tick = 0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				tick++;
				case (mode)
					RX_FREE: out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
					RX_HEAVY: out_stall <= ($urandom_range(0, 1) == 1);
					default: out_stall <= (tick % 5 < 2);
				endcase
			end
		end
	end

	initial begin
		int unsigned useful;
		int unsigned phase_words;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= '0;
		packet_size <= '0;
		last_byte <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_nonce_known(1'b0);
		foreach (directed_rows[i]) begin
			fixed_summary = '0;
			fixed_summary.kind = KIND_SUMMARY;
			fixed_summary.status = directed_rows[i].status;
			fixed_summary.code = directed_rows[i].code;
			fixed_summary.port = directed_rows[i].port;
			fixed_summary.addr = directed_rows[i].addr;
			fixed_summary.life = directed_rows[i].life;
			fixed_summary.nlen = directed_rows[i].nlen;
			fixed_summary.summary = 1'b1;
			fixed_summary_on = directed_rows[i].typed;
			build_row(directed_rows[i]);
			send_packet();
		end
		fixed_summary_on = 1'b0;

		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph == 0 || ph == N_PHASES - 1)
				set_nonce_known(1'b0);
			else if (ph == 1)
				set_nonce_known(1'b1);
			else
				set_nonce_known(1'($urandom_range(0, 1)));
			if (ph == 0) begin
				// hold the output off while a long nonce streams in
				hold_request = 1'b1;
				build_row(HOLD_ROW);
				send_packet();
			end
			phase_words = 0;
			while (phase_words < RANDOM_WORDS / N_PHASES) begin
				make_random_packet(useful);
				send_packet();
				phase_words += useful;
			end
		end

		in_valid <= 1'b0;
		while (parser_words_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("stun_attribute_parser regression: pass");
		else
			$display("stun_attribute_parser regression: fail");
		$finish;
	end

endmodule

// File: stun_attribute_parser.f
rtl/core/stap_pkg.sv
rtl/core/stap_parse.sv
rtl/core/stap_queue.sv
rtl/core/stap_emit.sv
rtl/core/stun_attribute_parser.sv
rtl/core/stap_checker.sv
verif/tb_stun_attribute_parser.sv
